>>> rtl/wfp_pkg.sv
package wfp_pkg;

    // Parse phases, one-hot
    typedef enum logic [10:0] {
        PH_RIFF  = 11'b000_0000_0001,
        PH_RSIZE = 11'b000_0000_0010,
        PH_WAVE  = 11'b000_0000_0100,
        PH_CID   = 11'b000_0000_1000,
        PH_CSIZE = 11'b000_0001_0000,
        PH_FMT   = 11'b000_0010_0000,
        PH_DATA  = 11'b000_0100_0000,
        PH_SKIP  = 11'b000_1000_0000,
        PH_PAD   = 11'b001_0000_0000,
        PH_DONE  = 11'b010_0000_0000,
        PH_ERR   = 11'b100_0000_0000
    } phase_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] DEPTH_16     = 16'd16;
    localparam logic [15:0] DEPTH_24     = 16'd24;

    localparam logic [1:0] KIND_AUDIO  = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_RIFF   = 4'd1;
    localparam logic [3:0] ERR_NO_WAVE   = 4'd2;
    localparam logic [3:0] ERR_SHORT_FMT = 4'd3;
    localparam logic [3:0] ERR_MISSING   = 4'd4;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
    localparam logic [3:0] ERR_ZERO      = 4'd6;
    localparam logic [3:0] ERR_DEPTH     = 4'd7;
    localparam logic [3:0] ERR_DATA_EARLY = 4'd8;

    // Pending result list, emitted lowest bit first
    localparam int PLAN_W    = 6;
    localparam int PL_ZERO   = 0;  // audio byte 0x00
    localparam int PL_HELD   = 1;  // audio byte = held low byte
    localparam int PL_BYTE   = 2;  // audio byte = current input byte
    localparam int PL_FORMAT = 3;
    localparam int PL_DONE   = 4;
    localparam int PL_ERROR  = 5;

    typedef struct packed {
        logic [PLAN_W-1:0] mask;
        logic [3:0]        code;
    } plan_t;

    typedef struct packed {
        logic restart;
        logic tag_shift;
        logic size_shift;
        logic cnt_inc;
        logic cnt_clr;
        logic chunk_load;
        logic fmt_store;
        logic set_fmt_seen;
        logic set_data_seen;
        logic data_init;
        logic hold_low;
        logic sample_clr;
    } cmd_t;

    typedef struct packed {
        logic cnt_is3;
        logic cnt_hit;
        logic next_is_riff;
        logic next_is_wave;
        logic tag_is_fmt;
        logic tag_is_data;
        logic size_lt16;
        logic size_zero;
        logic size_odd;
        logic chunk_odd;
        logic fmt_seen;
        logic data_seen;
        logic fmt_pcm;
        logic chan_rate_nz;
        logic depth_ok;
        logic depth24;
        logic sample_phase;
    } status_t;

endpackage

>>> rtl/wfp_ctrl.sv
module wfp_ctrl
    import wfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    start_of_file,
    input  logic    end_of_file,
    input  status_t st,
    output cmd_t    cmd,
    output plan_t   plan
);

    phase_t phase_reg;
    phase_t phase_next;

    always_comb
    begin
        phase_t     cur;
        logic       fs;
        logic       ds;
        logic       want_end;
        logic       end_odd;
        logic       want_fail;
        logic [3:0] fail_code;

        cmd        = '0;
        plan       = '0;
        phase_next = phase_reg;
        cur        = start_of_file ? PH_RIFF : phase_reg;
        fs         = st.fmt_seen;
        ds         = st.data_seen;
        want_end   = 1'b0;
        end_odd    = 1'b0;
        want_fail  = 1'b0;
        fail_code  = ERR_NONE;

        if (accept)
        begin
            cmd.restart = start_of_file;
            phase_next  = cur;
            case (cur)
                PH_RIFF, PH_WAVE, PH_CID:
                begin
                    cmd.tag_shift = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    if (st.cnt_is3)
                    begin
                        cmd.cnt_clr = 1'b1;
                        if (cur == PH_RIFF)
                        begin
                            if (!st.next_is_riff)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_NO_RIFF;
                            end
                            else
                                phase_next = PH_RSIZE;
                        end
                        else if (cur == PH_WAVE)
                        begin
                            if (!st.next_is_wave)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_NO_WAVE;
                            end
                            else
                                phase_next = PH_CID;
                        end
                        else
                            phase_next = PH_CSIZE;
                    end
                end
                PH_RSIZE:
                begin
                    cmd.size_shift = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    if (st.cnt_is3)
                    begin
                        cmd.cnt_clr = 1'b1;
                        phase_next  = PH_WAVE;
                    end
                end
                PH_CSIZE:
                begin
                    cmd.size_shift = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    if (st.cnt_is3)
                    begin
                        // chunk header complete: open the chunk
                        cmd.cnt_clr    = 1'b1;
                        cmd.chunk_load = 1'b1;
                        if (st.tag_is_fmt)
                        begin
                            if (st.size_lt16)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_SHORT_FMT;
                            end
                            else
                                phase_next = PH_FMT;
                        end
                        else if (st.tag_is_data)
                        begin
                            if (!fs)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_DATA_EARLY;
                            end
                            else if (!st.fmt_pcm)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_NOT_PCM;
                            end
                            else if (!st.chan_rate_nz)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_ZERO;
                            end
                            else if (!st.depth_ok)
                            begin
                                want_fail = 1'b1;
                                fail_code = ERR_DEPTH;
                            end
                            else
                            begin
                                plan.mask[PL_FORMAT] = 1'b1;
                                cmd.data_init        = 1'b1;
                                phase_next           = PH_DATA;
                                if (st.size_zero)
                                begin
                                    cmd.set_data_seen = 1'b1;
                                    ds                = 1'b1;
                                    want_end          = 1'b1;
                                    end_odd           = st.size_odd;
                                end
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                            if (st.size_zero)
                            begin
                                want_end = 1'b1;
                                end_odd  = st.size_odd;
                            end
                        end
                    end
                end
                PH_FMT:
                begin
                    cmd.fmt_store = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    if (st.cnt_hit)
                    begin
                        cmd.set_fmt_seen = 1'b1;
                        fs               = 1'b1;
                        want_end         = 1'b1;
                        end_odd          = st.chunk_odd;
                    end
                end
                PH_DATA:
                begin
                    cmd.cnt_inc = 1'b1;
                    if (st.depth24)
                        plan.mask[PL_BYTE] = 1'b1;
                    else if (!st.sample_phase)
                        cmd.hold_low = 1'b1;
                    else
                    begin
                        plan.mask[PL_ZERO] = 1'b1;
                        plan.mask[PL_HELD] = 1'b1;
                        plan.mask[PL_BYTE] = 1'b1;
                        cmd.sample_clr     = 1'b1;
                    end
                    if (st.cnt_hit)
                    begin
                        cmd.set_data_seen = 1'b1;
                        ds                = 1'b1;
                        want_end          = 1'b1;
                        end_odd           = st.chunk_odd;
                    end
                end
                PH_SKIP:
                begin
                    cmd.cnt_inc = 1'b1;
                    if (st.cnt_hit)
                    begin
                        want_end = 1'b1;
                        end_odd  = st.chunk_odd;
                    end
                end
                PH_PAD:
                begin
                    want_end = 1'b1;
                    end_odd  = 1'b0;
                end
                default:
                begin
                end
            endcase

            // close the chunk: pad byte, done, or back to the next header
            if (want_end)
            begin
                if (end_odd)
                    phase_next = PH_PAD;
                else if (fs && ds)
                begin
                    plan.mask[PL_DONE] = 1'b1;
                    phase_next         = PH_DONE;
                end
                else
                begin
                    phase_next  = PH_CID;
                    cmd.cnt_clr = 1'b1;
                end
            end

            if (want_fail)
            begin
                plan.mask[PL_ERROR] = 1'b1;
                plan.code           = fail_code;
                phase_next          = PH_ERR;
            end

            // file ends before parsing finished
            if (end_of_file && phase_next != PH_DONE && phase_next != PH_ERR)
            begin
                plan.mask[PL_ERROR] = 1'b1;
                plan.code           = ERR_MISSING;
                phase_next          = PH_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_RIFF;
        else
            phase_reg <= phase_next;
    end

endmodule

>>> rtl/wfp_datapath.sv
module wfp_datapath
    import wfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        start_of_file,
    input  cmd_t        cmd,
    output status_t     st,
    output logic [7:0]  held_byte,
    output logic [15:0] fmt_tag,
    output logic [15:0] fmt_channels,
    output logic [31:0] fmt_rate,
    output logic [15:0] fmt_align,
    output logic [31:0] fmt_byte_rate
);

    logic [31:0] cnt_reg,     cnt_next;
    logic [31:0] tag_reg,     tag_next;
    logic [31:0] size_reg,    size_next;
    logic [31:0] chunk_reg,   chunk_next;
    logic [15:0] ftag_reg,    ftag_next;
    logic [15:0] chan_reg,    chan_next;
    logic [31:0] rate_reg,    rate_next;
    logic [15:0] bits_reg,    bits_next;
    logic        fseen_reg,   fseen_next;
    logic        dseen_reg,   dseen_next;
    logic [7:0]  held_reg,    held_next;
    logic        sphase_reg,  sphase_next;
    logic [15:0] align_reg;
    logic [31:0] brate_reg;

    logic [31:0] cnt_eff;
    logic [31:0] cnt_plus;
    logic [31:0] tag_shifted;
    logic [31:0] size_shifted;

    assign cnt_eff      = start_of_file ? 32'd0 : cnt_reg;
    assign cnt_plus     = cnt_eff + 32'd1;
    assign tag_shifted  = {tag_reg[23:0], in_byte};
    assign size_shifted = {in_byte, size_reg[31:8]};

    always_comb
    begin
        st              = '0;
        st.cnt_is3      = (cnt_eff == 32'd3);
        st.cnt_hit      = (cnt_plus == chunk_reg);
        st.next_is_riff = (tag_shifted == TAG_RIFF);
        st.next_is_wave = (tag_shifted == TAG_WAVE);
        st.tag_is_fmt   = (tag_reg == TAG_FMT);
        st.tag_is_data  = (tag_reg == TAG_DATA);
        st.size_lt16    = (size_shifted < FMT_MIN_SIZE);
        st.size_zero    = (size_shifted == 32'd0);
        st.size_odd     = size_shifted[0];
        st.chunk_odd    = chunk_reg[0];
        st.fmt_seen     = fseen_reg;
        st.data_seen    = dseen_reg;
        st.fmt_pcm      = (ftag_reg == FMT_PCM);
        st.chan_rate_nz = (chan_reg != 16'd0) && (rate_reg != 32'd0);
        st.depth_ok     = (bits_reg == DEPTH_16) || (bits_reg == DEPTH_24);
        st.depth24      = (bits_reg == DEPTH_24);
        st.sample_phase = sphase_reg;
    end

    always_comb
    begin
        // restart clears everything before this byte acts
        cnt_next    = cmd.restart ? 32'd0 : cnt_reg;
        tag_next    = cmd.restart ? 32'd0 : tag_reg;
        size_next   = cmd.restart ? 32'd0 : size_reg;
        chunk_next  = cmd.restart ? 32'd0 : chunk_reg;
        ftag_next   = cmd.restart ? 16'd0 : ftag_reg;
        chan_next   = cmd.restart ? 16'd0 : chan_reg;
        rate_next   = cmd.restart ? 32'd0 : rate_reg;
        bits_next   = cmd.restart ? 16'd0 : bits_reg;
        fseen_next  = cmd.restart ? 1'b0 : fseen_reg;
        dseen_next  = cmd.restart ? 1'b0 : dseen_reg;
        held_next   = cmd.restart ? 8'd0 : held_reg;
        sphase_next = cmd.restart ? 1'b0 : sphase_reg;

        if (cmd.cnt_clr)
            cnt_next = 32'd0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_plus;

        if (cmd.tag_shift)
            tag_next = {tag_next[23:0], in_byte};
        if (cmd.size_shift)
            size_next = {in_byte, size_next[31:8]};
        if (cmd.chunk_load)
            chunk_next = size_shifted;

        if (cmd.fmt_store && cnt_eff[31:4] == 28'd0)
        begin
            case (cnt_eff[3:0])
                4'd0:  ftag_next[7:0]   = in_byte;
                4'd1:  ftag_next[15:8]  = in_byte;
                4'd2:  chan_next[7:0]   = in_byte;
                4'd3:  chan_next[15:8]  = in_byte;
                4'd4:  rate_next[7:0]   = in_byte;
                4'd5:  rate_next[15:8]  = in_byte;
                4'd6:  rate_next[23:16] = in_byte;
                4'd7:  rate_next[31:24] = in_byte;
                4'd14: bits_next[7:0]   = in_byte;
                4'd15: bits_next[15:8]  = in_byte;
                default:
                begin
                end
            endcase
        end

        if (cmd.set_fmt_seen)
            fseen_next = 1'b1;
        if (cmd.set_data_seen)
            dseen_next = 1'b1;

        if (cmd.data_init)
        begin
            held_next   = 8'd0;
            sphase_next = 1'b0;
        end
        else if (cmd.hold_low)
        begin
            held_next   = in_byte;
            sphase_next = 1'b1;
        end
        else if (cmd.sample_clr)
            sphase_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            tag_reg    <= '0;
            size_reg   <= '0;
            chunk_reg  <= '0;
            ftag_reg   <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            fseen_reg  <= 1'b0;
            dseen_reg  <= 1'b0;
            held_reg   <= '0;
            sphase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            tag_reg    <= tag_next;
            size_reg   <= size_next;
            chunk_reg  <= chunk_next;
            ftag_reg   <= ftag_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            fseen_reg  <= fseen_next;
            dseen_reg  <= dseen_next;
            held_reg   <= held_next;
            sphase_reg <= sphase_next;
        end
    end

    // Format math runs behind the saved fields; it settles long before the
    // data header that reports it.
    always_ff @(posedge clk)
    begin
        align_reg <= (chan_reg << 1) + chan_reg;
        brate_reg <= 32'(rate_reg * align_reg);
    end

    assign held_byte     = held_reg;
    assign fmt_tag       = ftag_reg;
    assign fmt_channels  = chan_reg;
    assign fmt_rate      = rate_reg;
    assign fmt_align     = align_reg;
    assign fmt_byte_rate = brate_reg;

endmodule

>>> rtl/wfp_emit.sv
module wfp_emit
    import wfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        plan_load,
    input  plan_t       plan,
    input  logic [7:0]  in_byte,
    input  logic [7:0]  held_byte,
    input  logic [15:0] fmt_tag,
    input  logic [15:0] fmt_channels,
    input  logic [31:0] fmt_rate,
    input  logic [15:0] fmt_align,
    input  logic [31:0] fmt_byte_rate,
    output logic        idle,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  audio_byte,
    output logic [15:0] format_tag,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [15:0] bits_per_sample,
    output logic [15:0] block_align,
    output logic [31:0] byte_rate,
    output logic [3:0]  error_code,
    output logic        last
);

    logic [PLAN_W-1:0] mask_reg,   mask_next;
    logic [7:0]        byte_reg;
    logic [7:0]        held_reg;
    logic [3:0]        code_reg;
    logic              valid_reg,  valid_next;

    logic [PLAN_W-1:0] sel;
    logic              load_out;

    assign sel      = mask_reg & (~mask_reg + PLAN_W'(1));
    assign load_out = (mask_reg != '0) && (!valid_reg || result_ready);
    assign idle     = (mask_reg == '0);

    always_comb
    begin
        mask_next  = mask_reg;
        valid_next = valid_reg;
        if (plan_load)
            mask_next = plan.mask;
        else if (load_out)
            mask_next = mask_reg & ~sel;
        if (load_out)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    // Capture this word's operands; the list drains from them.
    always_ff @(posedge clk)
    begin
        if (plan_load)
        begin
            byte_reg <= in_byte;
            held_reg <= held_byte;
            code_reg <= plan.code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            audio_byte      <= '0;
            format_tag      <= '0;
            channel_count   <= '0;
            sample_rate     <= '0;
            bits_per_sample <= '0;
            block_align     <= '0;
            byte_rate       <= '0;
            error_code      <= ERR_NONE;
            last            <= ((mask_reg & ~sel) == '0);
            if (sel[PL_ZERO])
                kind <= KIND_AUDIO;
            else if (sel[PL_HELD])
            begin
                kind       <= KIND_AUDIO;
                audio_byte <= held_reg;
            end
            else if (sel[PL_BYTE])
            begin
                kind       <= KIND_AUDIO;
                audio_byte <= byte_reg;
            end
            else if (sel[PL_FORMAT])
            begin
                kind            <= KIND_FORMAT;
                format_tag      <= fmt_tag;
                channel_count   <= fmt_channels;
                sample_rate     <= fmt_rate;
                bits_per_sample <= DEPTH_24;
                block_align     <= fmt_align;
                byte_rate       <= fmt_byte_rate;
            end
            else if (sel[PL_DONE])
                kind <= KIND_DONE;
            else
            begin
                kind       <= KIND_ERROR;
                error_code <= code_reg;
            end
        end
    end

    assign result_valid = valid_reg;

endmodule

>>> rtl/wave_file_parser_unit.sv
// WAV file parser.
// Input channel (byte_valid / byte_ready): one file byte per word, with
// start_of_file on the first byte of a file (restarts parsing) and
// end_of_file on its final byte.
// Output channel (result_valid / result_ready): one result per word. kind
// says audio byte, format ready, parse done or error; fields that do not
// belong to the kind read zero, and last marks the final result of a byte.
// 16-bit samples expand to three bytes (0x00, low, high); 24-bit data
// passes through.
// Throughput: header and skipped bytes, which yield no result, stream at one
// per cycle while the result list is empty. A byte that yields k results
// (k = 1..4) closes the input while the single output register drains the
// pending result list, one word per cycle while result_ready is high.
// The results of an accepted byte load the pending result list first and
// move from it into the output register.
// Reset: all parse state clears and the block waits for a RIFF tag.
// Stall: when result_ready is low the output word holds; the input stays
// open only while no results of earlier bytes are still pending.
module wave_file_parser_unit
    import wfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  audio_byte,
    output logic [15:0] format_tag,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [15:0] bits_per_sample,
    output logic [15:0] block_align,
    output logic [31:0] byte_rate,
    output logic [3:0]  error_code,
    output logic        last
);

    cmd_t        cmd;
    status_t     st;
    plan_t       plan;
    logic        accept;
    logic        idle;
    logic [7:0]  held_byte;
    logic [15:0] fmt_tag;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_align;
    logic [31:0] fmt_byte_rate;

    // Take a new word only when the result list is empty.
    assign byte_ready = idle;
    assign accept     = byte_valid && byte_ready;

    // Phase machine: decide commands and the results of each byte.
    wfp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .st            (st),
        .cmd           (cmd),
        .plan          (plan)
    );

    // Counters, tag and size shifters, saved format, format math.
    wfp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .start_of_file (start_of_file),
        .cmd           (cmd),
        .st            (st),
        .held_byte     (held_byte),
        .fmt_tag       (fmt_tag),
        .fmt_channels  (fmt_channels),
        .fmt_rate      (fmt_rate),
        .fmt_align     (fmt_align),
        .fmt_byte_rate (fmt_byte_rate)
    );

    // Result list and output register.
    wfp_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .plan_load       (accept),
        .plan            (plan),
        .in_byte         (in_byte),
        .held_byte       (held_byte),
        .fmt_tag         (fmt_tag),
        .fmt_channels    (fmt_channels),
        .fmt_rate        (fmt_rate),
        .fmt_align       (fmt_align),
        .fmt_byte_rate   (fmt_byte_rate),
        .idle            (idle),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .kind            (kind),
        .audio_byte      (audio_byte),
        .format_tag      (format_tag),
        .channel_count   (channel_count),
        .sample_rate     (sample_rate),
        .bits_per_sample (bits_per_sample),
        .block_align     (block_align),
        .byte_rate       (byte_rate),
        .error_code      (error_code),
        .last            (last)
    );

endmodule
